>>> design/kvl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvl_pkg
// Shared types and constants for the keyframe vector interpolator.
// ----------------------------------------------------------------------------
package kvl_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned COMP_W = 32;
    localparam int unsigned VEC_W  = 3 * COMP_W;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned SEG_W  = 6;

    localparam logic [1:0] STATUS_NORMAL = 2'd0;
    localparam logic [1:0] STATUS_BEFORE = 2'd1;
    localparam logic [1:0] STATUS_PAST   = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load_q;      // capture query time
        logic load_t0;     // capture start time and vector from read data
        logic load_t1;     // capture end time and vector from read data
        logic div_start;   // start the factor division
        logic mul_start;   // start the component multiplies
        logic hold_last;   // result is the captured start key as is
    } kvl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic q_lt_rd;     // query time below time read this cycle
        logic div_done;
        logic mul_done;
    } kvl_stat_t;

endpackage : kvl_pkg
`default_nettype wire

>>> design/kvl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kvl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule : kvl_ram
`default_nettype wire

>>> design/kvl_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvl_datapath
// Holds the segment endpoints, divides for the factor (one quotient bit a
// cycle) and interpolates the three components through one shared multiplier.
// ----------------------------------------------------------------------------
module kvl_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire kvl_pkg::kvl_cmd_t                cmd,
    output kvl_pkg::kvl_stat_t                    stat,
    input  wire logic [kvl_pkg::TIME_W-1:0]       query_time,
    input  wire logic [kvl_pkg::TIME_W-1:0]       rd_time,
    input  wire logic [kvl_pkg::VEC_W-1:0]        rd_vec,
    output logic      [kvl_pkg::VEC_W-1:0]        result_vec
);
    import kvl_pkg::*;

    localparam int unsigned DIV_CNT_W = $clog2(FRAC_W + 1);

    logic [TIME_W-1:0] q_reg;
    logic [TIME_W-1:0] t0_reg;
    logic [TIME_W-1:0] t1_reg;
    logic [VEC_W-1:0]  s_reg;
    logic [VEC_W-1:0]  e_reg;

    // Division: remainder below span, one quotient bit each cycle
    logic [TIME_W:0]          rem_reg;
    logic [TIME_W-1:0]        span_reg;
    logic [FRAC_W-1:0]        quo_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic                     div_busy_reg;
    logic                     div_done_reg;

    // Multiply: one component per cycle, then add
    logic [1:0]               mul_idx_reg;
    logic                     mul_busy_reg;
    logic                     mul_done_reg;
    logic [VEC_W-1:0]         res_reg;
    logic signed [COMP_W+FRAC_W+1:0] prod_reg;
    logic                     prod_vld_reg;
    logic [1:0]               prod_idx_reg;

    logic [TIME_W:0]          rem_shift;
    logic [TIME_W:0]          rem_sub;
    logic signed [COMP_W:0]   diff;
    logic signed [COMP_W+FRAC_W+1:0] prod_next;
    logic signed [COMP_W-1:0] s_comp;
    logic signed [COMP_W-1:0] e_comp;
    logic signed [COMP_W-1:0] sp_comp;
    logic signed [COMP_W+FRAC_W+1:0] sum_wide;

    assign stat.q_lt_rd  = q_reg < rd_time;
    assign stat.div_done = div_done_reg;
    assign stat.mul_done = mul_done_reg;
    assign result_vec    = res_reg;

    assign rem_shift = {rem_reg[TIME_W-1:0], 1'b0};
    assign rem_sub   = rem_shift - {1'b0, span_reg};

    // Select the component under multiply
    always_comb begin
        s_comp  = $signed(s_reg[mul_idx_reg*COMP_W +: COMP_W]);
        e_comp  = $signed(e_reg[mul_idx_reg*COMP_W +: COMP_W]);
        sp_comp = $signed(s_reg[prod_idx_reg*COMP_W +: COMP_W]);
        diff    = {e_comp[COMP_W-1], e_comp} - {s_comp[COMP_W-1], s_comp};
        prod_next = diff * $signed({2'b00, quo_reg});
        // Arithmetic shift floors toward minus infinity
        sum_wide = (prod_reg >>> FRAC_W) + (COMP_W+FRAC_W+2)'(sp_comp);
    end

    // Capture operands
    always_ff @(posedge aclk) begin
        if (cmd.load_q) begin
            q_reg <= query_time;
        end
        if (cmd.load_t0) begin
            t0_reg <= rd_time;
            s_reg  <= rd_vec;
        end
        if (cmd.load_t1) begin
            t1_reg <= rd_time;
            e_reg  <= rd_vec;
        end
    end

    // Restoring divider; a query before the start key keeps a zero factor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            div_done_reg <= 1'b0;
            if (cmd.div_start) begin
                rem_reg      <= {1'b0, q_reg - t0_reg};
                span_reg     <= t1_reg - t0_reg;
                quo_reg      <= '0;
                if (q_reg < t0_reg) begin
                    div_done_reg <= 1'b1;
                end else begin
                    div_busy_reg <= 1'b1;
                    div_cnt_reg  <= DIV_CNT_W'(FRAC_W);
                end
            end else if (div_busy_reg) begin
                if (!rem_sub[TIME_W]) begin
                    rem_reg <= rem_sub;
                    quo_reg <= {quo_reg[FRAC_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[FRAC_W-2:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(1)) begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    // Multiply stage then add stage, one component each cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
            mul_idx_reg  <= '0;
        end else begin
            mul_done_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
            if (cmd.hold_last) begin
                res_reg <= s_reg;
            end
            if (cmd.mul_start) begin
                mul_busy_reg <= 1'b1;
                mul_idx_reg  <= '0;
            end else if (mul_busy_reg) begin
                prod_reg     <= prod_next;
                prod_idx_reg <= mul_idx_reg;
                prod_vld_reg <= 1'b1;
                mul_idx_reg  <= mul_idx_reg + 1'b1;
                if (mul_idx_reg == 2'd2) begin
                    mul_busy_reg <= 1'b0;
                end
            end
            if (prod_vld_reg) begin
                res_reg[prod_idx_reg*COMP_W +: COMP_W] <= sum_wide[COMP_W-1:0];
                if (prod_idx_reg == 2'd2) begin
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    // Check the span while dividing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
        end else if (div_busy_reg) begin
            assert (span_reg != '0)
                else $error("factor division with zero span");
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |-> !div_busy_reg)
        else $error("multiply started while divide busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done_reg |-> $past(div_busy_reg || cmd.div_start))
        else $error("divide done without running");
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done_reg |-> !mul_busy_reg)
        else $error("multiply done while busy");

endmodule : kvl_datapath
`default_nettype wire

>>> design/kvl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvl_ctrl
// Sequences loads, the linear key search and the result handshake.
// ----------------------------------------------------------------------------
module kvl_ctrl #(
    parameter int unsigned MAX_KEYS = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_kind,
    input  wire logic [kvl_pkg::CNT_W-1:0]      key_count,
    output logic                                ram_wr_en,
    output logic      [$clog2(MAX_KEYS)-1:0]    ram_rd_addr,
    output kvl_pkg::kvl_cmd_t                   cmd,
    input  wire kvl_pkg::kvl_stat_t             stat,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [kvl_pkg::SEG_W-1:0]      seg_out,
    output logic      [1:0]                     status_out
);
    import kvl_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_KEYS);
    localparam int unsigned NW  = $clog2(MAX_KEYS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SRCH_RD, ST_SRCH_CHK, ST_RD_T0, ST_CAP_T0,
        ST_RD_LAST, ST_CAP_LAST, ST_DIV, ST_MUL, ST_OUT
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   addr_reg;
    logic [AW-1:0]   seg_reg;
    logic [NW-1:0]   n_reg;
    logic [1:0]      status_reg;
    logic [NW-1:0]   n_clamp;
    logic [NW:0]     cnt_ext;
    logic            accept;
    logic            div_go_reg;
    logic            mul_go_reg;

    // Clamp the key count into 1..MAX_KEYS
    always_comb begin
        cnt_ext = (NW+1)'(key_count);
        if (cnt_ext == '0) begin
            n_clamp = NW'(1);
        end else if (cnt_ext > (NW+1)'(MAX_KEYS)) begin
            n_clamp = NW'(MAX_KEYS);
        end else begin
            n_clamp = cnt_ext[NW-1:0];
        end
    end

    assign s_ready    = state_reg == ST_IDLE;
    assign accept     = s_valid && s_ready;
    assign ram_wr_en  = accept && (s_kind == KIND_LOAD);
    assign m_valid    = state_reg == ST_OUT;
    assign seg_out    = SEG_W'(seg_reg);
    assign status_out = status_reg;

    // Read address follows the state; decode datapath commands
    always_comb begin
        ram_rd_addr = addr_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_CAP_T0:   cmd.load_t0 = 1'b1;
            ST_CAP_LAST: begin
                cmd.load_t0   = 1'b1;
            end
            default: ;
        endcase
        if (state_reg == ST_SRCH_CHK && stat.q_lt_rd) begin
            cmd.load_t1 = 1'b1;
        end
        cmd.load_q    = accept;
        cmd.div_start = div_go_reg;
        cmd.mul_start = mul_go_reg;
        cmd.hold_last = state_reg == ST_MUL
                        && (status_reg == STATUS_PAST || n_reg == NW'(1));
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            addr_reg   <= '0;
            seg_reg    <= '0;
            n_reg      <= NW'(1);
            status_reg <= STATUS_NORMAL;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && s_kind == KIND_QUERY) begin
                        n_reg      <= n_clamp;
                        status_reg <= STATUS_NORMAL;
                        seg_reg    <= '0;
                        if (n_clamp == NW'(1)) begin
                            addr_reg  <= '0;
                            state_reg <= ST_RD_LAST;
                        end else begin
                            addr_reg  <= AW'(1);
                            state_reg <= ST_SRCH_RD;
                        end
                    end
                end
                ST_SRCH_RD: state_reg <= ST_SRCH_CHK;
                ST_SRCH_CHK: begin
                    if (stat.q_lt_rd) begin
                        seg_reg   <= addr_reg - 1'b1;
                        addr_reg  <= addr_reg - 1'b1;
                        state_reg <= ST_RD_T0;
                    end else if (NW'(addr_reg) + 1'b1 == n_reg) begin
                        seg_reg    <= addr_reg;
                        status_reg <= STATUS_PAST;
                        state_reg  <= ST_RD_LAST;
                    end else begin
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= ST_SRCH_RD;
                    end
                end
                ST_RD_T0:  state_reg <= ST_CAP_T0;
                ST_CAP_T0: begin
                    if (stat.q_lt_rd) begin
                        status_reg <= STATUS_BEFORE;
                    end
                    state_reg <= ST_DIV;
                end
                ST_RD_LAST:  state_reg <= ST_CAP_LAST;
                ST_CAP_LAST: state_reg <= ST_MUL;
                ST_DIV: begin
                    if (stat.div_done) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (stat.mul_done || status_reg == STATUS_PAST
                        || n_reg == NW'(1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Step pulses, decoded from the registered state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;
        end else begin
            div_go_reg <= state_reg == ST_CAP_T0;
            mul_go_reg <= state_reg == ST_DIV && stat.div_done;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(seg_out))
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRCH_CHK) |-> (NW'(addr_reg) < n_reg))
        else $error("search ran past key count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg == STATUS_PAST && m_valid) |-> (NW'(seg_reg) + 1'b1 == n_reg))
        else $error("held result not at last key");

endmodule : kvl_ctrl
`default_nettype wire

>>> design/keyframe_vector_lerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_vector_lerp
// Keyframe table with linear interpolation of a 3-component vector.
// ----------------------------------------------------------------------------
// Sequence: a load is written when taken. A query searches the keys linearly, one read
// per key, then runs the factor division and a multiply pass over the three components
// before m_tvalid rises; before the first key the divide loop is skipped, and past the
// last key or with a single key both are skipped and the start key is held.
// Throughput: one query at a time; input is taken again the cycle after the result.
// Reset: synchronous active-low aresetn idles and sets key_count to 1; table uncleared.
module keyframe_vector_lerp #(
    parameter int unsigned MAX_KEYS = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [6:0]    cfg_wr_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          s_tuser,   // kind
    // key_slot[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
    // key_z[133:102], query_time[165:134], zero pad [167:166]
    input  wire logic [167:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // value_x[31:0], value_y[63:32], value_z[95:64], segment[101:96],
    // status[103:102]
    output logic [103:0]       m_tdata
);
    import kvl_pkg::*;

    localparam int unsigned AW = $clog2(MAX_KEYS);

    logic [CNT_W-1:0]  key_count_reg;
    logic              ram_wr_en;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              slot_ok;
    logic [TIME_W-1:0] rd_time;
    logic [VEC_W-1:0]  rd_vec;
    logic [VEC_W-1:0]  result_vec;
    logic [SEG_W-1:0]  seg_out;
    logic [1:0]        status_out;
    kvl_cmd_t          cmd;
    kvl_stat_t         stat;

    // Hold the key count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= CNT_W'(1);
        end else if (cfg_wr_en) begin
            key_count_reg <= cfg_wr_data;
        end
    end

    // Drop loads to slots beyond the table
    assign slot_ok = 32'(s_tdata[5:0]) < MAX_KEYS;
    assign wr_addr = AW'(s_tdata[5:0]);

    kvl_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_time_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en && slot_ok),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[37:6]),
        .rd_addr (rd_addr),
        .rd_data (rd_time)
    );

    kvl_ram #(.WIDTH(VEC_W), .DEPTH(MAX_KEYS)) u_value_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en && slot_ok),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[133:38]),
        .rd_addr (rd_addr),
        .rd_data (rd_vec)
    );

    kvl_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_kind      (s_tuser),
        .key_count   (key_count_reg),
        .ram_wr_en   (ram_wr_en),
        .ram_rd_addr (rd_addr),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .seg_out     (seg_out),
        .status_out  (status_out)
    );

    kvl_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .query_time (s_tdata[165:134]),
        .rd_time    (rd_time),
        .rd_vec     (rd_vec),
        .result_vec (result_vec)
    );

    assign m_tdata = {status_out, seg_out, result_vec};

endmodule : keyframe_vector_lerp
`default_nettype wire
